/* hdl/i2c_register_access_master_core_defines.svh */
// Assertion macros shared by the I2C register access master RTL.
// No dependencies; included by files that carry concurrent assertions.
// Both macros have empty bodies for synthesis.
`ifndef I2C_REGISTER_ACCESS_MASTER_CORE_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked assertion with asynchronous active-low reset as disable
`define IRM_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("irm assertion failed");
// Same, with a caller-supplied message
`define IRM_ASSERT_MSG(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);
`else
`define IRM_ASSERT(name, clk, rst_n, prop)
`define IRM_ASSERT_MSG(name, clk, rst_n, prop, msg)
`endif

`endif

/* hdl/irm_pkg.sv */
// Types and constants for the I2C register access master.
// No dependencies; used by the interfaces, the sequencer and the top level.
package irm_pkg;

	localparam int unsigned DEV_ADDR_W = 7;
	localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET = 7'd93;

	// Command codes
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// One half-bit tick of input
	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] reg_address;
		logic [7:0]  byte_count;
		logic [7:0]  write_data;
		logic        sda_level;
	} irm_in_t;

	// Line levels and status for one tick
	typedef struct packed {
		logic       scl_level;
		logic       sda_release;
		logic [7:0] read_data;
		logic       read_valid;
		logic       read_last;
		logic       write_taken;
		logic       busy_res;
		logic       done_res;
		logic       nak_error;
	} irm_out_t;

endpackage

/* hdl/irm_if.sv */
// Valid/ready stream interfaces for the I2C register access master.
// Depends on irm_pkg for the payload types.
interface irm_in_if;
	logic              valid;
	logic              ready;
	irm_pkg::irm_in_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface irm_out_if;
	logic              valid;
	logic              ready;
	irm_pkg::irm_out_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/irm_seq.sv */
// Bus sequencer: state registers and one half-bit step of the I2C master.
// Depends on irm_pkg and the assertion macro header.
`include "i2c_register_access_master_core_defines.svh"

module irm_seq #(
	parameter int unsigned ACK_POLLS = 50
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  irm_pkg::irm_in_t                  item,
	input  logic [irm_pkg::DEV_ADDR_W-1:0]    device_address,
	output irm_pkg::irm_out_t                 result
);

	// Phase codes
	localparam logic [4:0] PH_IDLE     = 5'd0;
	localparam logic [4:0] PH_RS_A     = 5'd2;
	localparam logic [4:0] PH_ST_B     = 5'd3;
	localparam logic [4:0] PH_ST_C     = 5'd4;
	localparam logic [4:0] PH_ST_D     = 5'd5;
	localparam logic [4:0] PH_WB_SET   = 5'd6;
	localparam logic [4:0] PH_WB_HIGH  = 5'd7;
	localparam logic [4:0] PH_WB_LOW   = 5'd8;
	localparam logic [4:0] PH_ACK_POLL = 5'd9;
	localparam logic [4:0] PH_ACK_LOW  = 5'd10;
	localparam logic [4:0] PH_RB_HIGH  = 5'd11;
	localparam logic [4:0] PH_RB_LOW   = 5'd12;
	localparam logic [4:0] PH_AK_A     = 5'd13;
	localparam logic [4:0] PH_AK_B     = 5'd14;
	localparam logic [4:0] PH_AK_C     = 5'd15;
	localparam logic [4:0] PH_AK_D     = 5'd16;
	localparam logic [4:0] PH_NK_A     = 5'd17;
	localparam logic [4:0] PH_NK_B     = 5'd18;
	localparam logic [4:0] PH_NK_C     = 5'd19;
	localparam logic [4:0] PH_SP_A     = 5'd20;
	localparam logic [4:0] PH_SP_B     = 5'd21;
	localparam logic [4:0] PH_SP_C     = 5'd22;
	localparam logic [4:0] PH_EP_A     = 5'd23;
	localparam logic [4:0] PH_EP_B     = 5'd24;
	localparam logic [4:0] PH_EP_C     = 5'd25;

	// Which byte is in flight
	localparam logic [2:0] STG_ADDR_W = 3'd0;
	localparam logic [2:0] STG_REG_H  = 3'd1;
	localparam logic [2:0] STG_REG_L  = 3'd2;
	localparam logic [2:0] STG_ADDR_R = 3'd3;
	localparam logic [2:0] STG_DATA   = 3'd4;

	localparam logic [7:0] POLL_LIMIT = 8'(ACK_POLLS);

	logic [4:0]  phase_q, phase_d;
	logic [2:0]  stage_q, stage_d;
	logic [2:0]  bit_index_q, bit_index_d;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  bytes_left_q, bytes_left_d;
	logic [7:0]  poll_count_q, poll_count_d;
	logic [15:0] held_reg_q, held_reg_d;
	logic        is_read_q, is_read_d;
	logic [7:0]  poll_next;
	logic [7:0]  bytes_dec;
	logic        data_or_stop;
	logic        msb;

	assign msb       = shift_q[7];
	assign poll_next = poll_count_q + 8'd1;
	assign bytes_dec = bytes_left_q - 8'd1;

	// One half-bit step
	always_comb begin
		phase_d      = phase_q;
		stage_d      = stage_q;
		bit_index_d  = bit_index_q;
		shift_d      = shift_q;
		bytes_left_d = bytes_left_q;
		poll_count_d = poll_count_q;
		held_reg_d   = held_reg_q;
		is_read_d    = is_read_q;
		data_or_stop = 1'b0;
		result       = '0;
		result.scl_level   = 1'b1;
		result.sda_release = 1'b1;
		result.busy_res    = 1'b1;

		case (phase_q)
			PH_IDLE: begin
				result.busy_res = 1'b0;
				if (item.opcode inside {irm_pkg::OP_WRITE, irm_pkg::OP_READ}) begin
					result.busy_res = 1'b1;
					held_reg_d      = item.reg_address;
					bytes_left_d    = item.byte_count;
					is_read_d       = (item.opcode == irm_pkg::OP_READ);
					stage_d         = STG_ADDR_W;
					phase_d         = PH_ST_B;
				end
			end
			PH_RS_A: begin
				result.scl_level = 1'b0;
				phase_d          = PH_ST_B;
			end
			PH_ST_B: phase_d = PH_ST_C;
			PH_ST_C: begin
				result.sda_release = 1'b0;
				phase_d            = PH_ST_D;
			end
			PH_ST_D: begin
				result.scl_level   = 1'b0;
				result.sda_release = 1'b0;
				shift_d            = {device_address, (stage_q == STG_ADDR_R)};
				bit_index_d        = 3'd0;
				phase_d            = PH_WB_SET;
			end
			PH_WB_SET: begin
				result.scl_level   = 1'b0;
				result.sda_release = msb;
				phase_d            = PH_WB_HIGH;
			end
			PH_WB_HIGH: begin
				result.sda_release = msb;
				phase_d            = PH_WB_LOW;
			end
			PH_WB_LOW: begin
				result.scl_level   = 1'b0;
				result.sda_release = msb;
				shift_d            = {shift_q[6:0], 1'b0};
				if (bit_index_q == 3'd7) begin
					bit_index_d  = 3'd0;
					poll_count_d = 8'd0;
					phase_d      = PH_ACK_POLL;
				end else begin
					bit_index_d = bit_index_q + 3'd1;
					phase_d     = PH_WB_SET;
				end
			end
			// Target ACK: SDA pulled low while SCL is high
			PH_ACK_POLL: begin
				if (!item.sda_level) begin
					poll_count_d = 8'd0;
					phase_d      = PH_ACK_LOW;
				end else if (poll_next >= POLL_LIMIT) begin
					poll_count_d = 8'd0;
					phase_d      = PH_EP_A;
				end else begin
					poll_count_d = poll_next;
				end
			end
			PH_ACK_LOW: begin
				result.scl_level = 1'b0;
				bit_index_d      = 3'd0;
				case (stage_q)
					STG_ADDR_W: begin
						shift_d = held_reg_q[15:8];
						stage_d = STG_REG_H;
						phase_d = PH_WB_SET;
					end
					STG_REG_H: begin
						shift_d = held_reg_q[7:0];
						stage_d = STG_REG_L;
						phase_d = PH_WB_SET;
					end
					STG_REG_L: begin
						if (is_read_q) begin
							stage_d = STG_ADDR_R;
							phase_d = PH_RS_A;
						end else begin
							data_or_stop = 1'b1;
						end
					end
					STG_ADDR_R: begin
						if (bytes_left_q == 8'd0) begin
							phase_d = PH_SP_A;
						end else begin
							shift_d = 8'd0;
							phase_d = PH_RB_HIGH;
						end
					end
					default: data_or_stop = 1'b1;
				endcase
				// Next write data byte or stop
				if (data_or_stop) begin
					if (bytes_left_q != 8'd0) begin
						shift_d            = item.write_data;
						result.write_taken = 1'b1;
						bytes_left_d       = bytes_dec;
						stage_d            = STG_DATA;
						phase_d            = PH_WB_SET;
					end else begin
						phase_d = PH_SP_A;
					end
				end
			end
			PH_RB_HIGH: begin
				shift_d = {shift_q[6:0], item.sda_level};
				if (bit_index_q == 3'd7) begin
					result.read_valid = 1'b1;
					result.read_data  = {shift_q[6:0], item.sda_level};
					result.read_last  = (bytes_left_q == 8'd1);
				end
				phase_d = PH_RB_LOW;
			end
			PH_RB_LOW: begin
				result.scl_level = 1'b0;
				if (bit_index_q == 3'd7) begin
					bit_index_d  = 3'd0;
					bytes_left_d = bytes_dec;
					phase_d      = (bytes_dec != 8'd0) ? PH_AK_A : PH_NK_A;
				end else begin
					bit_index_d = bit_index_q + 3'd1;
					phase_d     = PH_RB_HIGH;
				end
			end
			PH_AK_A: begin
				result.scl_level   = 1'b0;
				result.sda_release = 1'b0;
				phase_d            = PH_AK_B;
			end
			PH_AK_B: begin
				result.sda_release = 1'b0;
				phase_d            = PH_AK_C;
			end
			PH_AK_C: begin
				result.scl_level   = 1'b0;
				result.sda_release = 1'b0;
				phase_d            = PH_AK_D;
			end
			PH_AK_D: begin
				result.scl_level = 1'b0;
				shift_d          = 8'd0;
				bit_index_d      = 3'd0;
				phase_d          = PH_RB_HIGH;
			end
			PH_NK_A: begin
				result.scl_level = 1'b0;
				phase_d          = PH_NK_B;
			end
			PH_NK_B: phase_d = PH_NK_C;
			PH_NK_C: begin
				result.scl_level = 1'b0;
				phase_d          = PH_SP_A;
			end
			PH_SP_A: begin
				result.scl_level   = 1'b0;
				result.sda_release = 1'b0;
				phase_d            = PH_SP_B;
			end
			PH_SP_B: begin
				result.sda_release = 1'b0;
				phase_d            = PH_SP_C;
			end
			PH_SP_C: begin
				result.done_res = 1'b1;
				phase_d         = PH_IDLE;
			end
			// Abort after ACK timeout: stop with error flag
			PH_EP_A, PH_EP_B: begin
				result.sda_release = 1'b0;
				phase_d            = (phase_q == PH_EP_A) ? PH_EP_B : PH_EP_C;
			end
			PH_EP_C: begin
				result.done_res  = 1'b1;
				result.nak_error = 1'b1;
				phase_d          = PH_IDLE;
			end
			default: begin
				result.busy_res = 1'b0;
				phase_d         = PH_IDLE;
			end
		endcase
	end

	// State registers advance once per processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			stage_q      <= STG_ADDR_W;
			bit_index_q  <= 3'd0;
			shift_q      <= 8'd0;
			bytes_left_q <= 8'd0;
			poll_count_q <= 8'd0;
			held_reg_q   <= 16'd0;
			is_read_q    <= 1'b0;
		end else if (adv) begin
			phase_q      <= phase_d;
			stage_q      <= stage_d;
			bit_index_q  <= bit_index_d;
			shift_q      <= shift_d;
			bytes_left_q <= bytes_left_d;
			poll_count_q <= poll_count_d;
			held_reg_q   <= held_reg_d;
			is_read_q    <= is_read_d;
		end
	end

	`IRM_ASSERT(a_done_returns_idle, clk, arst_n, adv && result.done_res |=> phase_q == PH_IDLE)
	`IRM_ASSERT(a_taken_sends_data, clk, arst_n,
		adv && result.write_taken |=> stage_q == STG_DATA && phase_q == PH_WB_SET)
	`IRM_ASSERT_MSG(a_poll_bounded, clk, arst_n, poll_count_q < POLL_LIMIT,
		"ACK poll counter reached its limit")
	`IRM_ASSERT_MSG(a_nak_only_on_abort, clk, arst_n,
		adv && result.nak_error |-> phase_q == PH_EP_C && result.done_res,
		"NAK flagged outside the abort stop")

endmodule

/* hdl/i2c_register_access_master_core.sv */
// I2C register access master: top level with input, config and result registers.
// Depends on irm_pkg, irm_if (irm_in_if, irm_out_if), irm_seq and the macro header.
//
// Usage: every transfer on req is one half-bit tick of the I2C bus. Its opcode
// starts a register write or read when the master is idle; sda_level is the
// sampled SDA line. Each tick yields exactly one transfer on rsp carrying the
// SCL level, the SDA drive, read bytes and status for that tick.
// A tick accepted into the input stage is stepped through the sequencer and held in
// the result register when that register is free or draining; rsp.valid then rises.
// Throughput: one tick per cycle while rsp is not stalled; the sequencer step between
// the input register and the result register is combinational.
// cfg_we with cfg_wdata writes the 7-bit device address; write it only while no
// tick is in flight.
// Reset: arst_n returns the bus sequencer to idle (lines released), empties both
// stages and sets the device address to 93.
// Stall: while rsp.ready is low the result register holds, the input stage
// fills once and req.ready then drops until rsp drains.
`include "i2c_register_access_master_core_defines.svh"

module i2c_register_access_master_core #(
	parameter int unsigned ACK_POLLS = 50
) (
	input  logic                              clk,
	input  logic                              arst_n,
	irm_in_if.sink                            req,
	irm_out_if.source                         rsp,
	input  logic                              cfg_we,
	input  logic [irm_pkg::DEV_ADDR_W-1:0]    cfg_wdata
);

	logic [irm_pkg::DEV_ADDR_W-1:0] dev_addr_q;
	irm_pkg::irm_in_t               item_s1;
	logic                           valid_s1;
	irm_pkg::irm_out_t              res_d;
	irm_pkg::irm_out_t              res_q;
	logic                           res_valid_q;
	logic                           adv;

	// Step a tick when the result register is free or draining
	assign adv       = valid_s1 && (!res_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign rsp.valid = res_valid_q;
	assign rsp.payload = res_q;

	// Device address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= irm_pkg::DEV_ADDR_RESET;
		end else if (cfg_we) begin
			dev_addr_q <= cfg_wdata;
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.payload;
		end
	end

	irm_seq #(
		.ACK_POLLS (ACK_POLLS)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.item           (item_s1),
		.device_address (dev_addr_q),
		.result         (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	`IRM_ASSERT(a_no_overwrite, clk, arst_n, res_valid_q && !rsp.ready |-> !adv)
	`IRM_ASSERT_MSG(a_stage_drains, clk, arst_n,
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1),
		"pending tick lost from input stage")
	`IRM_ASSERT(a_step_fills_result, clk, arst_n, adv |=> res_valid_q)

endmodule

/* verif/i2c_register_access_master_core_tb.sv */
// Self-checking bench for the I2C register access master: drives bus ticks on req,
// predicts SCL/SDA and status per tick, and checks every rsp transfer in order.
// Depends on irm_pkg, irm_if and the i2c_register_access_master_core RTL.
module i2c_register_access_master_core_tb;

	localparam int ACK_POLL_LIMIT = 50;
	localparam int RANDOM_TICKS   = 150;
	localparam int QUIET_TICKS    = 80;
	localparam int HOLD_CYCLES    = 80;
	localparam int REPORT_LIMIT   = 10;

	// Opcodes the package does not name
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_SPARE = 2'd3;

	// Bus sequencer phases
	typedef enum logic [4:0] {
		BUS_IDLE, BUS_RESTART, BUS_START_HI, BUS_START_FALL, BUS_START_LOW,
		BIT_SETUP, BIT_HIGH, BIT_LOW, ACK_WAIT, ACK_DONE,
		RD_HIGH, RD_LOW, MACK_SETUP, MACK_HIGH, MACK_LOW, MACK_RELEASE,
		MNAK_SETUP, MNAK_HIGH, MNAK_LOW, STOP_SETUP, STOP_HIGH, STOP_RISE,
		ABORT_A, ABORT_B, ABORT_RISE
	} bus_phase_t;

	// Which byte is on the wire
	typedef enum logic [2:0] {
		ST_ADDR_WR, ST_REG_HI, ST_REG_LO, ST_ADDR_RD, ST_DATA
	} byte_stage_t;

	// Tick predictor plus the queue of line levels still owed by the block
	class irm_tick_board;
		logic [6:0]         dev_addr;
		bus_phase_t         phase;
		byte_stage_t        stage;
		logic [2:0]         bit_idx;
		logic [7:0]         shift;
		logic [7:0]         bytes_to_go;
		logic [7:0]         polls;
		logic [15:0]        held_reg;
		logic               is_rd;
		irm_pkg::irm_out_t  owed_ticks[$];
		int                 fail_count;

		function void reset_state();
			dev_addr = irm_pkg::DEV_ADDR_RESET;
			phase = BUS_IDLE;
			stage = ST_ADDR_WR;
			bit_idx = '0;
			shift = '0;
			bytes_to_go = '0;
			polls = '0;
			held_reg = '0;
			is_rd = 1'b0;
			owed_ticks.delete();
			fail_count = 0;
		endfunction

		function int pending();
			return owed_ticks.size();
		endfunction

		// One half-bit tick of the master
		function irm_pkg::irm_out_t advance_bus(irm_pkg::irm_in_t it);
			irm_pkg::irm_out_t o;
			logic top_bit;
			logic send_next;
			o = '0;
			o.scl_level = 1'b1;
			o.sda_release = 1'b1;
			o.busy_res = 1'b1;
			top_bit = shift[7];
			send_next = 1'b0;
			case (phase)
				BUS_IDLE: begin
					o.busy_res = 1'b0;
					if (it.opcode == irm_pkg::OP_WRITE || it.opcode == irm_pkg::OP_READ) begin
						o.busy_res = 1'b1;
						held_reg = it.reg_address;
						bytes_to_go = it.byte_count;
						is_rd = (it.opcode == irm_pkg::OP_READ);
						stage = ST_ADDR_WR;
						phase = BUS_START_HI;
					end
				end
				BUS_RESTART: begin
					o.scl_level = 1'b0;
					phase = BUS_START_HI;
				end
				BUS_START_HI: phase = BUS_START_FALL;
				BUS_START_FALL: begin
					o.sda_release = 1'b0;
					phase = BUS_START_LOW;
				end
				BUS_START_LOW: begin
					o.scl_level = 1'b0;
					o.sda_release = 1'b0;
					shift = {dev_addr, stage == ST_ADDR_RD};
					bit_idx = '0;
					phase = BIT_SETUP;
				end
				BIT_SETUP: begin
					o.scl_level = 1'b0;
					o.sda_release = top_bit;
					phase = BIT_HIGH;
				end
				BIT_HIGH: begin
					o.sda_release = top_bit;
					phase = BIT_LOW;
				end
				BIT_LOW: begin
					o.scl_level = 1'b0;
					o.sda_release = top_bit;
					shift = {shift[6:0], 1'b0};
					if (bit_idx == 3'd7) begin
						bit_idx = '0;
						polls = '0;
						phase = ACK_WAIT;
					end else begin
						bit_idx = bit_idx + 3'd1;
						phase = BIT_SETUP;
					end
				end
				// target pulls SDA low to acknowledge, else count toward timeout
				ACK_WAIT: begin
					if (!it.sda_level) begin
						polls = '0;
						phase = ACK_DONE;
					end else begin
						polls = polls + 8'd1;
						if (polls >= ACK_POLL_LIMIT) begin
							polls = '0;
							phase = ABORT_A;
						end
					end
				end
				ACK_DONE: begin
					o.scl_level = 1'b0;
					bit_idx = '0;
					case (stage)
						ST_ADDR_WR: begin
							shift = held_reg[15:8];
							stage = ST_REG_HI;
							phase = BIT_SETUP;
						end
						ST_REG_HI: begin
							shift = held_reg[7:0];
							stage = ST_REG_LO;
							phase = BIT_SETUP;
						end
						ST_REG_LO: begin
							if (is_rd) begin
								stage = ST_ADDR_RD;
								phase = BUS_RESTART;
							end else begin
								send_next = 1'b1;
							end
						end
						ST_ADDR_RD: begin
							if (bytes_to_go == 0) begin
								phase = STOP_SETUP;
							end else begin
								shift = '0;
								phase = RD_HIGH;
							end
						end
						default: send_next = 1'b1;
					endcase
					if (send_next) begin
						if (bytes_to_go != 0) begin
							shift = it.write_data;
							o.write_taken = 1'b1;
							bytes_to_go = bytes_to_go - 8'd1;
							stage = ST_DATA;
							phase = BIT_SETUP;
						end else begin
							phase = STOP_SETUP;
						end
					end
				end
				// read byte, MSB first, sampled with SCL high
				RD_HIGH: begin
					shift = {shift[6:0], it.sda_level};
					if (bit_idx == 3'd7) begin
						o.read_valid = 1'b1;
						o.read_data = shift;
						o.read_last = (bytes_to_go == 8'd1);
					end
					phase = RD_LOW;
				end
				RD_LOW: begin
					o.scl_level = 1'b0;
					if (bit_idx == 3'd7) begin
						bit_idx = '0;
						bytes_to_go = bytes_to_go - 8'd1;
						phase = (bytes_to_go != 0) ? MACK_SETUP : MNAK_SETUP;
					end else begin
						bit_idx = bit_idx + 3'd1;
						phase = RD_HIGH;
					end
				end
				MACK_SETUP: begin
					o.scl_level = 1'b0;
					o.sda_release = 1'b0;
					phase = MACK_HIGH;
				end
				MACK_HIGH: begin
					o.sda_release = 1'b0;
					phase = MACK_LOW;
				end
				MACK_LOW: begin
					o.scl_level = 1'b0;
					o.sda_release = 1'b0;
					phase = MACK_RELEASE;
				end
				MACK_RELEASE: begin
					o.scl_level = 1'b0;
					shift = '0;
					bit_idx = '0;
					phase = RD_HIGH;
				end
				MNAK_SETUP: begin
					o.scl_level = 1'b0;
					phase = MNAK_HIGH;
				end
				MNAK_HIGH: phase = MNAK_LOW;
				MNAK_LOW: begin
					o.scl_level = 1'b0;
					phase = STOP_SETUP;
				end
				STOP_SETUP: begin
					o.scl_level = 1'b0;
					o.sda_release = 1'b0;
					phase = STOP_HIGH;
				end
				STOP_HIGH: begin
					o.sda_release = 1'b0;
					phase = STOP_RISE;
				end
				STOP_RISE: begin
					o.done_res = 1'b1;
					phase = BUS_IDLE;
				end
				// timeout: SDA low under high SCL, then release for stop
				ABORT_A: begin
					o.sda_release = 1'b0;
					phase = ABORT_B;
				end
				ABORT_B: begin
					o.sda_release = 1'b0;
					phase = ABORT_RISE;
				end
				ABORT_RISE: begin
					o.done_res = 1'b1;
					o.nak_error = 1'b1;
					phase = BUS_IDLE;
				end
				default: begin
					o.busy_res = 1'b0;
					phase = BUS_IDLE;
				end
			endcase
			return o;
		endfunction

		function void note_tick(irm_pkg::irm_in_t it);
			owed_ticks.push_back(advance_bus(it));
		endfunction

		function void check_tick(irm_pkg::irm_out_t got);
			irm_pkg::irm_out_t exp;
			logic bad;
			if (owed_ticks.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("%0t: rsp transfer with nothing owed: %h", $time, got);
				return;
			end
			exp = owed_ticks.pop_front();
			bad = (got.scl_level !== exp.scl_level)
				|| (got.sda_release !== exp.sda_release)
				|| (got.read_data !== exp.read_data) || (got.read_valid !== exp.read_valid)
				|| (got.read_last !== exp.read_last) || (got.write_taken !== exp.write_taken)
				|| (got.busy_res !== exp.busy_res) || (got.done_res !== exp.done_res)
				|| (got.nak_error !== exp.nak_error);
			if (bad) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT) begin
					$display("%0t: exp scl=%b sda=%b rd=%h rv=%b rl=%b wt=%b by=%b dn=%b nk=%b",
						$time, exp.scl_level, exp.sda_release, exp.read_data,
						exp.read_valid, exp.read_last, exp.write_taken, exp.busy_res,
						exp.done_res, exp.nak_error);
					$display("%0t: got scl=%b sda=%b rd=%h rv=%b rl=%b wt=%b by=%b dn=%b nk=%b",
						$time, got.scl_level, got.sda_release, got.read_data,
						got.read_valid, got.read_last, got.write_taken, got.busy_res,
						got.done_res, got.nak_error);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [irm_pkg::DEV_ADDR_W-1:0] cfg_wdata;

	irm_in_if  req_if ();
	irm_out_if rsp_if ();

	irm_tick_board board;
	int  ticks_sent;
	bit  quiet;
	bit  hold_req;

	i2c_register_access_master_core #(
		.ACK_POLLS (ACK_POLL_LIMIT)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// 10-unit clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: random stalls, one long hold-off on request, none when quiet
	initial begin : rsp_stall
		int gap;
		gap = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				gap = HOLD_CYCLES;
			end else if (!quiet && gap == 0 && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 11);
			end
			if (gap > 0) begin
				rsp_if.ready <= 1'b0;
				gap--;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// Check every rsp transfer
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			board.check_tick(rsp_if.payload);
	end

	// One req transfer, with an optional idle burst ahead of it
	task automatic send_tick(input irm_pkg::irm_in_t it);
		int n;
		n = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
		if (n > 0) begin
			@(negedge clk);
			req_if.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		req_if.valid <= 1'b1;
		req_if.payload <= it;
		do @(posedge clk); while (!req_if.ready);
		board.note_tick(it);
		ticks_sent++;
	endtask

	// Stop offering and wait until every owed tick has come back
	task automatic wait_drained();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
	endtask

	task automatic write_address(input logic [irm_pkg::DEV_ADDR_W-1:0] addr);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= addr;
		board.dev_addr = addr;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int pick_ack_delay(input bit slow);
		if (slow || $urandom_range(0, 19) == 0)
			return ACK_POLL_LIMIT - 1;
		return $urandom_range(0, 3);
	endfunction

	// One command tick, then ticks until the master is idle again. The target acknowledges
	// each byte after a random number of polls below ACK_POLL_LIMIT, except at ACK slot nak_slot.
	task automatic run_access(input logic [1:0] op, input logic [15:0] reg_addr,
		input logic [7:0] count, input int nak_slot, input bit slow_ack);
		irm_pkg::irm_in_t it;
		int  slot;
		int  polled;
		int  ack_delay;
		bit  first;
		slot = 0;
		polled = 0;
		ack_delay = pick_ack_delay(slow_ack);
		first = 1'b1;
		do begin
			it.opcode = first ? op : 2'($urandom_range(0, 3));
			it.reg_address = first ? reg_addr : 16'($urandom);
			it.byte_count = first ? count : 8'($urandom);
			it.write_data = 8'($urandom);
			it.sda_level = 1'($urandom);
			if (board.phase == ACK_WAIT) begin
				if (slot == nak_slot) begin
					it.sda_level = 1'b1;
				end else begin
					it.sda_level = (polled >= ack_delay) ? 1'b0 : 1'b1;
					polled++;
					if (!it.sda_level) begin
						slot++;
						polled = 0;
						ack_delay = pick_ack_delay(slow_ack);
					end
				end
			end
			first = 1'b0;
			send_tick(it);
		end while (board.phase != BUS_IDLE);
	endtask

	// Stimulus
	initial begin : stimulus
		int start_ticks;
		int slots;
		int nak_slot;
		logic [1:0] op;
		logic [7:0] count;
		board = new();
		board.reset_state();
		ticks_sent = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_if.valid = 1'b0;
		req_if.payload = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset address, field extremes, zero counts, unused opcodes
		run_access(irm_pkg::OP_WRITE, 16'hFFFF, 8'd1, -1, 1'b0);
		run_access(OP_SPARE, 16'hFFFF, 8'hFF, -1, 1'b0);
		run_access(OP_TICK, 16'h0000, 8'h00, -1, 1'b0);
		// slowest acknowledge that still passes, on a write with no data
		run_access(irm_pkg::OP_WRITE, 16'h00FF, 8'd0, -1, 1'b1);
		write_address(7'h7F);
		// read with ACK and final NACK, result side held off for a while
		hold_req = 1'b1;
		run_access(irm_pkg::OP_READ, 16'h0000, 8'd2, -1, 1'b0);
		write_address(7'h00);
		run_access(irm_pkg::OP_READ, 16'hFF00, 8'd0, -1, 1'b0);
		// ACK timeout on address+W
		run_access(irm_pkg::OP_WRITE, 16'($urandom), 8'd2, 0, 1'b0);
		write_address(irm_pkg::DEV_ADDR_RESET);

		// random transactions, occasional idle ticks and address changes
		start_ticks = ticks_sent;
		while (ticks_sent - start_ticks < RANDOM_TICKS) begin
			if (ticks_sent - start_ticks > RANDOM_TICKS - QUIET_TICKS)
				quiet = 1'b1;
			case ($urandom_range(0, 19))
				0: write_address(7'($urandom));
				1, 2: run_access($urandom_range(0, 1) ? OP_TICK : OP_SPARE,
					16'($urandom), 8'($urandom), -1, 1'b0);
				default: begin
					op = $urandom_range(0, 1) ? irm_pkg::OP_WRITE : irm_pkg::OP_READ;
					count = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(4, 16))
						: 8'($urandom_range(0, 3));
					slots = (op == irm_pkg::OP_WRITE) ? 3 + count : 4;
					nak_slot = ($urandom_range(0, 6) == 0) ? $urandom_range(0, slots - 1) : -1;
					run_access(op, 16'($urandom), count, nak_slot, 1'b0);
				end
			endcase
		end

		wait_drained();
		repeat (4) @(negedge clk);
		if (board.fail_count == 0 && board.pending() == 0) begin
			$display("i2c_register_access_master_core_tb: done, clean");
		end else begin
			$display("i2c_register_access_master_core_tb: done, errors");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("i2c_register_access_master_core_tb: done, errors");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/irm_pkg.sv
hdl/irm_if.sv
hdl/irm_seq.sv
hdl/i2c_register_access_master_core.sv
verif/i2c_register_access_master_core_tb.sv
